>>> sv/ffga_pkg.sv
// ----------------------------------------------------------------------------
// First-fit gap allocator package
// Shared types and constants for the allocator and its cell engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ffga_pkg;

   // Operation codes carried in the operation field.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LOT_LENGTH = 2'd0;
   localparam logic [1:0] CSR_FRONT_GAP  = 2'd1;
   localparam logic [1:0] CSR_BACK_GAP   = 2'd2;

   // Field widths fixed by the interface.
   localparam int unsigned LEN_W  = 11;
   localparam int unsigned GAP_W  = 7;
   localparam int unsigned REQ_W  = 9;
   localparam int unsigned POS_W  = 10;

   // Command from the top level to the tree engine.
   typedef struct packed {
      logic clear;    // reset every cell to free
      logic search;   // find the first free run of a given length
      logic update;   // mark a range used or free
      logic used;     // value written by an update
   } tree_cmd_type;

   // Status from the tree engine.
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } tree_sts_type;

endpackage : ffga_pkg

`default_nettype wire

>>> sv/ffga_tree.sv
// ----------------------------------------------------------------------------
// First-fit gap allocator cell line
// Holds one used bit per cell in a word memory; answers first-fit searches
// by word-serial reads and range updates by word-serial read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module ffga_tree #(
   parameter int unsigned CELLS   = 1279,
   parameter int unsigned POS_W_I = 11
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire ffga_pkg::tree_cmd_type cmd,
   input  wire logic [POS_W_I-1:0]    arg_lo,    // search: last cell, update: first
   input  wire logic [POS_W_I-1:0]    arg_hi,    // update: last cell
   input  wire logic [POS_W_I-1:0]    arg_need,  // search: run length
   output ffga_pkg::tree_sts_type     sts,
   output logic [POS_W_I-1:0]         found_start
);

   localparam int unsigned WW     = 32;
   localparam int unsigned WORDS  = (CELLS + WW - 1) / WW;
   localparam int unsigned WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned BIT_W  = $clog2(WW);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   // Word memory: one bit per cell, set when used.
   logic [WW-1:0] mem [WORDS];
   logic [WW-1:0] rdata_ff;
   logic          we;
   logic [WA_W-1:0] waddr;
   logic [WW-1:0] wdata;
   logic [WA_W-1:0] raddr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [WA_W-1:0]     addr_ff, addr_in;
   logic [POS_W_I-1:0]  run_ff, run_in;
   logic [BIT_W:0]      bit_ff, bit_in;     // bit within the current word
   logic                search_ff, search_in;
   logic                used_ff, used_in;
   logic                done_ff, done_in;
   logic                found_ff, found_in;
   logic [POS_W_I-1:0]  start_ff, start_in;
   logic [POS_W_I-1:0]  lo_ff, hi_ff, need_ff;
   logic [POS_W_I-1:0]  lo_in, hi_in, need_in;
   logic [WW-1:0]       word_ff, word_in;

   // Cell number of the current bit.
   logic [POS_W_I-1:0] cell_idx;
   assign cell_idx = POS_W_I'({addr_ff, bit_ff[BIT_W-1:0]});

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      run_in    = run_ff;
      bit_in    = bit_ff;
      search_in = search_ff;
      used_in   = used_ff;
      done_in   = 1'b0;
      found_in  = found_ff;
      start_in  = start_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      need_in   = need_ff;
      word_in   = word_ff;
      we        = 1'b0;
      waddr     = addr_ff;
      wdata     = word_ff;
      raddr     = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               addr_in   = '0;
               run_in    = '0;
               bit_in    = '0;
               found_in  = 1'b0;
               start_in  = '0;
               lo_in     = arg_lo;
               hi_in     = arg_hi;
               need_in   = arg_need;
               search_in = cmd.search;
               used_in   = cmd.used;
               if (cmd.clear) begin
                  state_in = ST_CLEAR;
               end else if (cmd.search) begin
                  raddr    = '0;
                  state_in = ST_READ;
               end else if (cmd.update) begin
                  addr_in  = WA_W'(arg_lo >> BIT_W);
                  raddr    = WA_W'(arg_lo >> BIT_W);
                  state_in = ST_READ;
               end
            end
         end
         ST_CLEAR: begin
            // One word per cycle back to all free.
            we    = 1'b1;
            wdata = '0;
            if (addr_ff == WA_W'(WORDS - 1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_READ: begin
            // Read data arrives this cycle.
            word_in  = rdata_ff;
            bit_in   = '0;
            state_in = search_ff ? ST_SCAN : ST_WRITE;
         end
         ST_SCAN: begin
            // One cell per cycle along the word.
            if (cell_idx > lo_ff) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (word_ff[bit_ff[BIT_W-1:0]]) begin
               run_in = '0;
            end else begin
               run_in = run_ff + 1'b1;
               if (run_ff + 1'b1 == need_ff) begin
                  found_in = 1'b1;
                  start_in = POS_W_I'(cell_idx + 1'b1 - need_ff);
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            if (state_in == ST_SCAN) begin
               if (bit_ff == (BIT_W+1)'(WW - 1)) begin
                  if (addr_ff == WA_W'(WORDS - 1)) begin
                     done_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     addr_in  = addr_ff + 1'b1;
                     raddr    = addr_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         ST_WRITE: begin
            // Set or clear the cells of this word that fall inside the range.
            if (cell_idx >= lo_ff && cell_idx <= hi_ff) begin
               word_in[bit_ff[BIT_W-1:0]] = used_ff;
            end
            if (bit_ff == (BIT_W+1)'(WW - 1)) begin
               we    = 1'b1;
               wdata = word_in;
               if (cell_idx >= hi_ff || addr_ff == WA_W'(WORDS - 1)) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  raddr    = addr_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      run_ff    <= run_in;
      bit_ff    <= bit_in;
      search_ff <= search_in;
      used_ff   <= used_in;
      start_ff  <= start_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      need_ff   <= need_in;
      word_ff   <= word_in;
   end

   assign sts.busy    = (state_ff != ST_IDLE);
   assign sts.done    = done_ff;
   assign sts.found   = found_ff;
   assign found_start = start_ff;

endmodule : ffga_tree

`default_nettype wire

>>> sv/first_fit_gap_allocator_top.sv
// ----------------------------------------------------------------------------
// First-fit gap allocator
// Leftmost-fit allocation of cell runs with guard gaps, and release by number.
// An allocate search reads each 32-cell word and then scans it cell by cell.
// A granted block then holds the cell engine while each word it spans is read and
// rewritten; a free looks up its table entry and then releases each word it spans.
// One transaction at a time, taken once the engine is idle, no result waits and
// no register write is offered. Reset, and a write to one of the three configuration
// registers, clears the line at one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_gap_allocator_top #(
   parameter int unsigned MAX_LENGTH   = 1024,
   parameter int unsigned MAX_GAP      = 127,
   parameter int unsigned MAX_REQUESTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic [10:0] req_block_size,
   input  wire logic [8:0]  req_request_number,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [9:0]       rsp_start_position,
   output logic             rsp_failed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);

   localparam int unsigned CELLS = MAX_LENGTH + 2 * MAX_GAP + 1;
   localparam int unsigned CP_W  = $clog2(CELLS + 1) + 1;
   localparam int unsigned RC_W  = $clog2(MAX_REQUESTS + 1);
   localparam int unsigned RA_W  = $clog2(MAX_REQUESTS);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_MARK   = 6'b000100,
      S_LOOKUP = 6'b001000,
      S_FREE   = 6'b010000,
      S_WAIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers, saturated on write.
   logic [10:0] lot_ff;
   logic [6:0]  fgap_ff, bgap_ff;
   logic        csr_hit;
   assign csr_hit = csr_valid && csr_ready && (csr_index == ffga_pkg::CSR_LOT_LENGTH
                    || csr_index == ffga_pkg::CSR_FRONT_GAP
                    || csr_index == ffga_pkg::CSR_BACK_GAP);

   // Grant table: valid, first and last cell per request number.
   logic [2*CP_W:0] gmem [MAX_REQUESTS];
   logic [2*CP_W:0] grd_ff;
   logic            gwe;
   logic [RA_W-1:0] gwa, gra;
   logic [2*CP_W:0] gwd;
   always_ff @(posedge clock) begin
      if (gwe) begin
         gmem[gwa] <= gwd;
      end
      grd_ff <= gmem[gra];
   end

   logic [RC_W-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [9:0]      pos_ff, pos_in;
   logic            fail_ff, fail_in;
   logic [CP_W-1:0] size_ff, size_in;
   logic [CP_W-1:0] lo_ff, lo_in, hi_ff, hi_in;

   // Tree engine.
   logic                  t_valid;
   ffga_pkg::tree_cmd_type t_cmd;
   ffga_pkg::tree_sts_type t_sts;
   logic [CP_W-1:0]       t_lo, t_hi, t_need, t_start;

   ffga_tree #(.CELLS(CELLS), .POS_W_I(CP_W)) u_tree (
      .clock(clock), .reset(reset), .cmd_valid(t_valid), .cmd(t_cmd),
      .arg_lo(t_lo), .arg_hi(t_hi), .arg_need(t_need),
      .sts(t_sts), .found_start(t_start)
   );

   logic            idle_all;
   assign idle_all  = (state_ff == S_IDLE) && !t_sts.busy && !t_sts.done;
   assign csr_ready = idle_all && !rsp_valid_ff;
   assign req_stall = !(idle_all && !rsp_valid_ff) || csr_valid;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   logic [CP_W-1:0] need_w, top_w, end_w;
   assign need_w = size_ff + CP_W'(fgap_ff) + CP_W'(bgap_ff);
   assign top_w  = CP_W'(lot_ff) + CP_W'(fgap_ff) + CP_W'(bgap_ff);
   assign end_w  = t_start + size_ff;

   logic rec_ok;
   assign rec_ok = (count_ff < RC_W'(MAX_REQUESTS));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pos_in       = pos_ff;
      fail_in      = fail_ff;
      size_in      = size_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      t_valid      = 1'b0;
      t_cmd        = '0;
      t_lo         = lo_ff;
      t_hi         = hi_ff;
      t_need       = need_w;
      gwe          = 1'b0;
      gwa          = count_ff[RA_W-1:0];
      gwd          = '0;
      gra          = RA_W'(req_request_number - 1'b1);
      if (csr_hit) begin
         count_in = '0;
         t_valid  = 1'b1;
         t_cmd.clear = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_operation == ffga_pkg::OP_ALLOC) begin
                  size_in = CP_W'(req_block_size);
                  if (req_block_size == '0) begin
                     // Zero size fails at once and records an empty entry.
                     pos_in = '0; fail_in = 1'b1; rsp_valid_in = 1'b1;
                     gwe = rec_ok;
                     if (rec_ok) count_in = count_ff + 1'b1;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end else if (req_request_number != '0
                            && RC_W'(req_request_number) <= count_ff) begin
                  state_in = S_LOOKUP;
               end else begin
                  gwe = rec_ok;
                  if (rec_ok) count_in = count_ff + 1'b1;
               end
            end
         end
         S_SEARCH: begin
            t_valid     = 1'b1;
            t_cmd.search = 1'b1;
            t_lo        = top_w;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            if (t_sts.done) begin
               if (t_sts.found && end_w <= CP_W'(lot_ff)) begin
                  lo_in    = t_start + CP_W'(fgap_ff);
                  hi_in    = t_start + CP_W'(fgap_ff) + size_ff - 1'b1;
                  pos_in   = t_start[9:0];
                  fail_in  = 1'b0;
                  state_in = S_MARK;
               end else begin
                  pos_in = '0; fail_in = 1'b1; rsp_valid_in = 1'b1;
                  gwe = rec_ok;
                  if (rec_ok) count_in = count_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_MARK: begin
            t_valid      = 1'b1;
            t_cmd.update = 1'b1;
            t_cmd.used   = 1'b1;
            gwe          = rec_ok;
            gwd          = {1'b1, lo_ff, hi_ff};
            if (rec_ok) count_in = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_FREE;
         end
         S_LOOKUP: begin
            // Table data for the requested entry is ready.
            lo_in    = grd_ff[2*CP_W-1:CP_W];
            hi_in    = grd_ff[CP_W-1:0];
            gwe      = rec_ok;
            gwd      = grd_ff;
            if (rec_ok) count_in = count_ff + 1'b1;
            if (grd_ff[2*CP_W]) begin
               t_valid      = 1'b1;
               t_cmd.update = 1'b1;
               t_lo         = grd_ff[2*CP_W-1:CP_W];
               t_hi         = grd_ff[CP_W-1:0];
               state_in     = S_FREE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            // Wait out the range update.
            if (t_sts.done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lot_ff       <= 11'(MAX_LENGTH);
         fgap_ff      <= '0;
         bgap_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ffga_pkg::CSR_LOT_LENGTH:
                  lot_ff <= (csr_data > 11'(MAX_LENGTH)) ? 11'(MAX_LENGTH) : csr_data;
               ffga_pkg::CSR_FRONT_GAP:
                  fgap_ff <= (csr_data > 11'(MAX_GAP)) ? 7'(MAX_GAP) : csr_data[6:0];
               ffga_pkg::CSR_BACK_GAP:
                  bgap_ff <= (csr_data > 11'(MAX_GAP)) ? 7'(MAX_GAP) : csr_data[6:0];
               default: ;
            endcase
         end
      end
      pos_ff  <= pos_in;
      fail_ff <= fail_in;
      size_ff <= size_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_position = pos_ff;
   assign rsp_failed         = fail_ff;

   // A failed grant never reports a nonzero start.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_start_position == '0)
      else $error("failed grant with nonzero start");

   // The request counter never passes the table depth.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RC_W'(MAX_REQUESTS))
      else $error("request counter overflow");

   // No new transaction is taken while the cell engine is busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      t_sts.busy |-> req_stall)
      else $error("request accepted while engine busy");

endmodule : first_fit_gap_allocator_top

`default_nettype wire
